>>> sv/rgb_hsv_cmy_colour_converter_defines.svh
// Assertion macros for the colour converter.
`ifndef RGB_HSV_CMY_COLOUR_CONVERTER_DEFINES_SVH
`define RGB_HSV_CMY_COLOUR_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// cons must hold whenever ante holds (same edge, or later if cons carries a delay)
`define RHC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc: implication check failed");
// expr must hold at every edge out of reset
`define RHC_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("rhc: invariant check failed");
`else
`define RHC_ASSERT_IMPL(label, ante, cons)
`define RHC_ASSERT_ALWAYS(label, expr)
`endif

`endif

>>> sv/rhc_pkg.sv
// Shared constants and types for the colour converter.
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COMP_W     = FRAC_BITS + 1;
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int LATENCY    = FRAC_BITS + 9;

  // hue6 / 6 as multiply by reciprocal and shift
  localparam int RECIP_SHIFT = FRAC_BITS + 6;
  localparam int RECIP_W     = FRAC_BITS + 4;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);

  typedef logic [COMP_W-1:0] comp_t;
  typedef comp_t [2:0] trip_t;

  localparam comp_t ONE = comp_t'(1) << FRAC_BITS;

  localparam logic [1:0] SPACE_RGB  = 2'd0;
  localparam logic [1:0] SPACE_HSV  = 2'd1;
  localparam logic [1:0] SPACE_CMY  = 2'd2;
  localparam logic [1:0] SPACE_NONE = 2'd3;  // unused code, forces zero output unless source and target are both NONE

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  typedef enum logic [1:0] {
    KIND_COPY = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_CONV = 2'd2
  } kind_t;

  // front end to back end
  typedef struct packed {
    logic  valid;
    logic  to_hsv;
    trip_t rgb;
    trip_t direct;
  } mid_t;

endpackage

>>> sv/rhc_div.sv
// Pipelined fixed-point divider: q = (x << FRAC_BITS) / den for x <= den.
`timescale 1ns / 1ps
module rhc_div import rhc_pkg::*; (
  input  logic  clk,
  input  comp_t x,
  input  comp_t den,
  output comp_t q
);

  comp_t rem_r [0:DIV_STAGES-1];
  comp_t den_r [0:DIV_STAGES-1];
  comp_t q_r   [0:DIV_STAGES-1];

  // integer bit: quotient is at most 1.0
  always_ff @(posedge clk) begin
    den_r[0] <= den;
    if (x >= den) begin
      q_r[0]   <= comp_t'(1);
      rem_r[0] <= x - den;
    end else begin
      q_r[0]   <= '0;
      rem_r[0] <= x;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    logic [COMP_W:0] r2;
    logic            ge;
    logic [COMP_W:0] diff;
    assign r2   = {rem_r[k-1], 1'b0};
    assign ge   = r2 >= {1'b0, den_r[k-1]};
    assign diff = r2 - {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      den_r[k] <= den_r[k-1];
      q_r[k]   <= {q_r[k-1][COMP_W-2:0], ge};
      rem_r[k] <= ge ? diff[COMP_W-1:0] : r2[COMP_W-1:0];
    end
  end

  assign q = q_r[DIV_STAGES-1];

endmodule

>>> sv/rhc_front.sv
// Front end: saturation, mode decode, HSV to RGB products and source/target selection.
`timescale 1ns / 1ps
module rhc_front import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  trip_t      in_comp,
  input  logic [1:0] src,
  input  logic [1:0] tgt,
  output mid_t       mid
);

  // stage 1: saturate, decode, split hue
  trip_t              sat_nxt;
  kind_t              kind_nxt;
  logic [FRAC_BITS-1:0] hh;
  logic [FRAC_BITS+2:0] h6;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sat_nxt[k] = (in_comp[k] > ONE) ? ONE : in_comp[k];
    end
    if (src == tgt) begin
      kind_nxt = KIND_COPY;
    end else if (src == SPACE_NONE || tgt == SPACE_NONE) begin
      kind_nxt = KIND_ZERO;
    end else begin
      kind_nxt = KIND_CONV;
    end
    hh = (sat_nxt[0] == ONE) ? '0 : sat_nxt[0][FRAC_BITS-1:0];
    h6 = {1'b0, hh, 2'b00} + {2'b00, hh, 1'b0};
  end

  logic                 v1_r;
  kind_t                kind1_r;
  logic [1:0]           src1_r, tgt1_r;
  trip_t                c1_r;
  logic [2:0]           sec1_r;
  logic [FRAC_BITS-1:0] f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    kind1_r <= kind_nxt;
    src1_r  <= src;
    tgt1_r  <= tgt;
    c1_r    <= sat_nxt;
    sec1_r  <= h6[FRAC_BITS+2:FRAC_BITS];
    f1_r    <= h6[FRAC_BITS-1:0];
  end

  // stage 2: p, s*f, s*(1-f)
  comp_t               oms, omf;
  logic [2*COMP_W-1:0] p_full, sf_full, s1f_full;

  always_comb begin
    oms      = ONE - c1_r[1];
    omf      = ONE - {1'b0, f1_r};
    p_full   = {{COMP_W{1'b0}}, c1_r[2]} * {{COMP_W{1'b0}}, oms};
    sf_full  = {{COMP_W{1'b0}}, c1_r[1]} * {{(COMP_W+1){1'b0}}, f1_r};
    s1f_full = {{COMP_W{1'b0}}, c1_r[1]} * {{COMP_W{1'b0}}, omf};
  end

  logic       v2_r;
  kind_t      kind2_r;
  logic [1:0] src2_r, tgt2_r;
  trip_t      c2_r;
  logic [2:0] sec2_r;
  comp_t      p2_r, sf2_r, s1f2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    kind2_r <= kind1_r;
    src2_r  <= src1_r;
    tgt2_r  <= tgt1_r;
    c2_r    <= c1_r;
    sec2_r  <= sec1_r;
    p2_r    <= p_full[FRAC_BITS +: COMP_W];
    sf2_r   <= sf_full[FRAC_BITS +: COMP_W];
    s1f2_r  <= s1f_full[FRAC_BITS +: COMP_W];
  end

  // stage 3: q and t
  logic [2*COMP_W-1:0] q_full, t_full;

  always_comb begin
    q_full = {{COMP_W{1'b0}}, c2_r[2]} * {{COMP_W{1'b0}}, ONE - sf2_r};
    t_full = {{COMP_W{1'b0}}, c2_r[2]} * {{COMP_W{1'b0}}, ONE - s1f2_r};
  end

  logic       v3_r;
  kind_t      kind3_r;
  logic [1:0] src3_r, tgt3_r;
  trip_t      c3_r;
  logic [2:0] sec3_r;
  comp_t      p3_r, q3_r, t3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    kind3_r <= kind2_r;
    src3_r  <= src2_r;
    tgt3_r  <= tgt2_r;
    c3_r    <= c2_r;
    sec3_r  <= sec2_r;
    p3_r    <= p2_r;
    q3_r    <= q_full[FRAC_BITS +: COMP_W];
    t3_r    <= t_full[FRAC_BITS +: COMP_W];
  end

  // stage 4: pick RGB and the non-HSV result
  trip_t hsv_rgb, rgb_nxt, direct_nxt;
  comp_t v;

  always_comb begin
    v = c3_r[2];
    if (c3_r[1] == '0) begin
      hsv_rgb = {v, v, v};
    end else begin
      case (sec3_r)
        3'd0:    hsv_rgb = {p3_r, t3_r, v};
        3'd1:    hsv_rgb = {p3_r, v, q3_r};
        3'd2:    hsv_rgb = {t3_r, v, p3_r};
        3'd3:    hsv_rgb = {v, q3_r, p3_r};
        3'd4:    hsv_rgb = {v, p3_r, t3_r};
        default: hsv_rgb = {q3_r, p3_r, v};
      endcase
    end
    case (src3_r)
      SPACE_HSV: rgb_nxt = hsv_rgb;
      SPACE_CMY: rgb_nxt = {ONE - c3_r[2], ONE - c3_r[1], ONE - c3_r[0]};
      default:   rgb_nxt = c3_r;
    endcase
    case (kind3_r)
      KIND_COPY: direct_nxt = c3_r;
      KIND_ZERO: direct_nxt = '0;
      default: begin
        if (tgt3_r == SPACE_CMY) begin
          direct_nxt = {ONE - rgb_nxt[2], ONE - rgb_nxt[1], ONE - rgb_nxt[0]};
        end else begin
          direct_nxt = rgb_nxt;
        end
      end
    endcase
  end

  mid_t mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r.valid <= 1'b0;
    end else begin
      mid_r.valid <= v3_r;
    end
    mid_r.to_hsv <= (kind3_r == KIND_CONV) && (tgt3_r == SPACE_HSV);
    mid_r.rgb    <= rgb_nxt;
    mid_r.direct <= direct_nxt;
  end

  assign mid = mid_r;

endmodule

>>> sv/rhc_back.sv
// Back end: RGB to HSV with two pipelined dividers, hue assembly and output registers.
`timescale 1ns / 1ps
module rhc_back import rhc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  mid_t  mid,
  output logic  out_valid,
  output trip_t out_comp
);

  // stage B1: max, min, delta, sector base
  comp_t      mx, mn, a, b;
  logic [1:0] base;

  always_comb begin
    mx = mid.rgb[0];
    mn = mid.rgb[0];
    for (int k = 1; k < 3; k++) begin
      if (mid.rgb[k] > mx) mx = mid.rgb[k];
      if (mid.rgb[k] < mn) mn = mid.rgb[k];
    end
    if (mid.rgb[0] == mx) begin
      base = 2'd0; a = mid.rgb[1]; b = mid.rgb[2];
    end else if (mid.rgb[1] == mx) begin
      base = 2'd1; a = mid.rgb[2]; b = mid.rgb[0];
    end else begin
      base = 2'd2; a = mid.rgb[0]; b = mid.rgb[1];
    end
  end

  typedef struct packed {
    logic       valid;
    logic       to_hsv;
    trip_t      direct;
    comp_t      mx;
    logic       mx_zero;
    logic       delta_zero;
    logic [1:0] base;
    logic       neg;
  } side_t;

  side_t b1_r;
  comp_t delta_r, mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.valid <= 1'b0;
    end else begin
      b1_r.valid <= mid.valid;
    end
    b1_r.to_hsv     <= mid.to_hsv;
    b1_r.direct     <= mid.direct;
    b1_r.mx         <= mx;
    b1_r.mx_zero    <= (mx == '0);
    b1_r.delta_zero <= (mx == mn);
    b1_r.base       <= base;
    b1_r.neg        <= (a < b);
    delta_r         <= mx - mn;
    mag_r           <= (a >= b) ? a - b : b - a;
  end

  comp_t q_sat, q_hue;

  rhc_div u_div_sat (.clk(clk), .x(delta_r), .den(b1_r.mx), .q(q_sat));
  rhc_div u_div_hue (.clk(clk), .x(mag_r),   .den(delta_r), .q(q_hue));

  // side data rides alongside the dividers
  side_t side_r [0:DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) side_r[k].valid <= 1'b0;
    end else begin
      side_r[0].valid <= b1_r.valid;
      for (int k = 1; k < DIV_STAGES; k++) side_r[k].valid <= side_r[k-1].valid;
    end
    side_r[0].to_hsv     <= b1_r.to_hsv;
    side_r[0].direct     <= b1_r.direct;
    side_r[0].mx         <= b1_r.mx;
    side_r[0].mx_zero    <= b1_r.mx_zero;
    side_r[0].delta_zero <= b1_r.delta_zero;
    side_r[0].base       <= b1_r.base;
    side_r[0].neg        <= b1_r.neg;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_r[k].to_hsv     <= side_r[k-1].to_hsv;
      side_r[k].direct     <= side_r[k-1].direct;
      side_r[k].mx         <= side_r[k-1].mx;
      side_r[k].mx_zero    <= side_r[k-1].mx_zero;
      side_r[k].delta_zero <= side_r[k-1].delta_zero;
      side_r[k].base       <= side_r[k-1].base;
      side_r[k].neg        <= side_r[k-1].neg;
    end
  end

  side_t sd;
  assign sd = side_r[DIV_STAGES-1];

  // stage B2: hue times six, wrapped
  logic [FRAC_BITS+2:0] base_v, qt, six_one, h6_nxt;

  always_comb begin
    base_v  = {sd.base, 1'b0, {FRAC_BITS{1'b0}}};
    qt      = {2'b00, q_hue};
    six_one = {3'b110, {FRAC_BITS{1'b0}}};
    if (sd.delta_zero) begin
      h6_nxt = '0;
    end else if (!sd.neg) begin
      h6_nxt = base_v + qt;
    end else if (base_v >= qt) begin
      h6_nxt = base_v - qt;
    end else begin
      h6_nxt = six_one + base_v - qt;
    end
  end

  logic                 v2_r, hsv2_r;
  trip_t                dir2_r;
  comp_t                sat2_r, val2_r;
  logic [FRAC_BITS+2:0] h6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= sd.valid;
    end
    hsv2_r <= sd.to_hsv;
    dir2_r <= sd.direct;
    sat2_r <= sd.mx_zero ? '0 : q_sat;
    val2_r <= sd.mx;
    h6_r   <= h6_nxt;
  end

  // stage B3: divide by six through the reciprocal
  logic                                 v3_r, hsv3_r;
  trip_t                                dir3_r;
  comp_t                                sat3_r, val3_r;
  logic [FRAC_BITS+3+RECIP_W-1:0]       prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    hsv3_r <= hsv2_r;
    dir3_r <= dir2_r;
    sat3_r <= sat2_r;
    val3_r <= val2_r;
    prod_r <= {{RECIP_W{1'b0}}, h6_r} * {{(FRAC_BITS+3){1'b0}}, RECIP};
  end

  // stage B4: output register
  logic  out_valid_r;
  trip_t out_comp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v3_r;
    end
    out_comp_r <= hsv3_r ? {val3_r, sat3_r, prod_r[RECIP_SHIFT +: COMP_W]} : dir3_r;
  end

  assign out_valid = out_valid_r;
  assign out_comp  = out_comp_r;

endmodule

>>> sv/rgb_hsv_cmy_colour_converter.sv
// Top level of the RGB / HSV / CMY colour converter.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------------
//  input    | in_first, in_second, in_third          | start high, busy low at edge
//  result   | out_first, out_second, out_third       | out_valid, one cycle, no stall
//  config   | cfg_we, cfg_index, cfg_data            | write at edge with cfg_we high
//
//  One colour per clock; busy never rises.
//  Saturation and hue come from two bit-per-stage dividers.
//  Synchronous active-low reset clears the valid chain and sets the config registers to RGB source, HSV target.
//  The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`include "rgb_hsv_cmy_colour_converter_defines.svh"
module rgb_hsv_cmy_colour_converter import rhc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  comp_t      in_first,
  input  comp_t      in_second,
  input  comp_t      in_third,
  output logic       out_valid,
  output comp_t      out_first,
  output comp_t      out_second,
  output comp_t      out_third,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [1:0] cfg_data
);

  // configuration registers
  logic [1:0] src_r, tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SPACE_RGB;
      tgt_r <= SPACE_HSV;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE: src_r <= cfg_data;
        CFG_TARGET: tgt_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // fully pipelined: a transaction is taken every cycle
  assign busy = 1'b0;

  logic  in_txn;
  trip_t in_comp;
  mid_t  mid;
  trip_t out_comp;

  assign in_txn  = start && !busy;
  assign in_comp = {in_third, in_second, in_first};

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_txn),
    .in_comp (in_comp),
    .src     (src_r),
    .tgt     (tgt_r),
    .mid     (mid)
  );

  rhc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mid      (mid),
    .out_valid(out_valid),
    .out_comp (out_comp)
  );

  assign out_first  = out_comp[0];
  assign out_second = out_comp[1];
  assign out_third  = out_comp[2];

  // every transaction leaves after the fixed latency, and nothing else does
  `RHC_ASSERT_IMPL(a_txn_out, start && !busy, ##LATENCY out_valid)
  `RHC_ASSERT_IMPL(a_out_txn, out_valid, $past(start, LATENCY))
  `RHC_ASSERT_IMPL(a_out_range, out_valid,
                   out_first <= ONE && out_second <= ONE && out_third <= ONE)
  `RHC_ASSERT_ALWAYS(a_never_busy, !busy)

endmodule
